FILE: src/assert_macros.svh
// assertion macros for the cache tag store rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check under reset qualification
`define SACL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// check that also holds through reset
`define SACL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SACL_ASSERT(lbl, clk, rstn, prop, msg)
`define SACL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: src/sacl_pkg.sv
// types and constants of the set-associative lru cache tag store
// no dependencies; used by sacl_if, sacl_regs, sacl_lookup, the top level and the testbench
package sacl_pkg;

  localparam int MAX_SET_BITS = 6;
  localparam int MAX_WAYS     = 4;
  localparam int ADDR_BITS    = 64;

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int RANK_W   = WAY_W;
  localparam int OLD_W    = RANK_W + 1;
  localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
  localparam int CNT_W    = 32;

  // configuration register widths and port
  localparam int SB_CFG_W = 3;
  localparam int BB_CFG_W = 6;
  localparam int WU_CFG_W = 3;
  localparam int SHIFT_W  = BB_CFG_W + 1;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;

  // register indexes (byte address is four times the index)
  localparam logic [1:0] REG_SET_BITS   = 2'd0;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS_USED  = 2'd2;

  typedef struct packed {
    logic [SB_CFG_W-1:0] set_bits;
    logic [BB_CFG_W-1:0] block_bits;
    logic [WU_CFG_W-1:0] ways_used;
  } cfg_t;

  // one memory row holds every way of a set
  typedef struct packed {
    logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag;
    logic [MAX_WAYS-1:0]                valid;
    logic [MAX_WAYS-1:0][RANK_W-1:0]    rank;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic hit;
    logic evict;
  } look_res_t;

  typedef enum logic {ST_IDLE, ST_LOOK} st_t;

endpackage

FILE: src/sacl_if.sv
// valid/ready channel interfaces for access items and result items
// depends on sacl_pkg for field widths
interface sacl_in_if;
  import sacl_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] access_address;
  modport source (output valid, output access_address, input ready);
  modport sink (input valid, input access_address, output ready);
endinterface

interface sacl_out_if;
  import sacl_pkg::*;
  logic             valid;
  logic             ready;
  logic             was_hit;
  logic             did_evict;
  logic [CNT_W-1:0] hit_total;
  logic [CNT_W-1:0] miss_total;
  logic [CNT_W-1:0] evict_total;
  modport source (output valid, output was_hit, output did_evict, output hit_total,
                  output miss_total, output evict_total, input ready);
  modport sink (input valid, input was_hit, input did_evict, input hit_total,
                input miss_total, input evict_total, output ready);
endinterface

FILE: src/sacl_ram.sv
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule

FILE: src/sacl_regs.sv
// apb-style configuration registers of the cache tag store
// depends on sacl_pkg
module sacl_regs (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [sacl_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [sacl_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [sacl_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                     cfg_pready,
  output sacl_pkg::cfg_t           cfg
);
  import sacl_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_hit;
  logic [1:0] reg_idx;

  assign reg_idx    = cfg_paddr[3:2];
  assign wr_hit     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  // register write decode; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_hit) begin
      case (reg_idx)
        REG_SET_BITS:   cfg_nxt.set_bits   = cfg_pwdata[SB_CFG_W-1:0];
        REG_BLOCK_BITS: cfg_nxt.block_bits = cfg_pwdata[BB_CFG_W-1:0];
        REG_WAYS_USED:  cfg_nxt.ways_used  = cfg_pwdata[WU_CFG_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.set_bits   <= '0;
      cfg_r.block_bits <= '0;
      cfg_r.ways_used  <= WU_CFG_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read-back mux
  always_comb begin
    case (reg_idx)
      REG_SET_BITS:   cfg_prdata = CFG_DW'(cfg_r.set_bits);
      REG_BLOCK_BITS: cfg_prdata = CFG_DW'(cfg_r.block_bits);
      REG_WAYS_USED:  cfg_prdata = CFG_DW'(cfg_r.ways_used);
      default:        cfg_prdata = '0;
    endcase
  end

  assign cfg = cfg_r;
endmodule

FILE: src/sacl_lookup.sv
// tag compare, victim choice and lru rank update for one set row
// depends on sacl_pkg
module sacl_lookup (
  input  sacl_pkg::row_t                   row_rd,
  input  logic                             row_ok,
  input  logic [sacl_pkg::ADDR_BITS-1:0]   tag,
  input  logic [sacl_pkg::WU_CFG_W-1:0]    ways_used,
  output sacl_pkg::row_t                   row_wr,
  output sacl_pkg::look_res_t              res
);
  import sacl_pkg::*;

  logic [WCNT_W-1:0]                ways_eff;
  logic [MAX_WAYS-1:0]              in_use;
  logic [MAX_WAYS-1:0]              vld;
  logic [MAX_WAYS-1:0][RANK_W-1:0]  rk;
  logic                             hit_found;
  logic                             free_found;
  logic [WAY_W-1:0]                 hit_way;
  logic [WAY_W-1:0]                 free_way;
  logic [WAY_W-1:0]                 vic;
  logic [WAY_W-1:0]                 sel_way;
  logic [OLD_W-1:0]                 old_rank;

  // clamp the way count to 1..MAX_WAYS
  always_comb begin
    if (ways_used == '0) begin
      ways_eff = WCNT_W'(1);
    end else if (int'(ways_used) > MAX_WAYS) begin
      ways_eff = WCNT_W'(MAX_WAYS);
    end else begin
      ways_eff = WCNT_W'(ways_used);
    end
  end

  // a row never written reads as all invalid with rank zero
  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      in_use[i] = (i < int'(ways_eff));
      vld[i]    = row_ok & row_rd.valid[i];
      rk[i]     = row_ok ? row_rd.rank[i] : '0;
    end
  end

  // first matching way, first free way, oldest way
  always_comb begin
    hit_found  = 1'b0;
    free_found = 1'b0;
    hit_way    = '0;
    free_way   = '0;
    vic        = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (!hit_found && in_use[i] && vld[i] && row_rd.tag[i] == tag) begin
        hit_found = 1'b1;
        hit_way   = WAY_W'(i);
      end
      if (!free_found && in_use[i] && !vld[i]) begin
        free_found = 1'b1;
        free_way   = WAY_W'(i);
      end
    end
    for (int i = 1; i < MAX_WAYS; i++) begin
      if (in_use[i] && rk[i] > rk[vic]) begin
        vic = WAY_W'(i);
      end
    end
  end

  // pick the touched way and its previous age
  always_comb begin
    res.hit   = hit_found;
    res.evict = 1'b0;
    if (hit_found) begin
      sel_way  = hit_way;
      old_rank = {1'b0, rk[hit_way]};
    end else if (free_found) begin
      sel_way  = free_way;
      old_rank = OLD_W'(MAX_WAYS);
    end else begin
      sel_way   = vic;
      old_rank  = {1'b0, rk[vic]};
      res.evict = 1'b1;
    end
  end

  // age the younger ways, make the touched way most recent
  always_comb begin
    row_wr.tag   = row_rd.tag;
    row_wr.valid = vld;
    row_wr.rank  = rk;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (in_use[i] && WAY_W'(i) != sel_way && vld[i] && {1'b0, rk[i]} < old_rank &&
          rk[i] != RANK_W'(MAX_WAYS - 1)) begin
        row_wr.rank[i] = rk[i] + RANK_W'(1);
      end
    end
    row_wr.rank[sel_way]  = '0;
    row_wr.valid[sel_way] = 1'b1;
    if (!hit_found) begin
      row_wr.tag[sel_way] = tag;
    end
  end
endmodule

FILE: src/set_assoc_cache_lru_sim.sv
// top level of the set-associative cache tag store with lru replacement
// depends on sacl_pkg, sacl_if, sacl_ram, sacl_regs, sacl_lookup, assert_macros.svh
//
// usage:
//   in_item carries one access address per item (valid/ready). out_item returns
//   exactly one result per access: hit flag, eviction flag and the saturating
//   hit, miss and eviction totals after that access.
//   the cfg_ apb port holds set_bits (0x0), block_bits (0x4) and ways_used
//   (0x8); write them only while no access is in flight.
// timing:
//   an item is taken in the idle cycle; its set row is read from the tag ram
//   there and compared, updated and written back in the lookup state, which
//   also loads the result into the output register. a new item is taken only
//   after the previous one has been written back, set by the read-then-write
//   of the single row ram port pair.
// stall:
//   while an earlier result waits on out_item, the next item is still taken,
//   but its write-back and result wait until the output register is free.
// reset:
//   rst_n (synchronous, active low) clears the per-set row valid flags, the
//   totals and the registers at once; no clearing pass is needed.
module set_assoc_cache_lru_sim (
  input  logic                        clk,
  input  logic                        rst_n,
  sacl_in_if.sink                     in_item,
  sacl_out_if.source                  out_item,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [sacl_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [sacl_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [sacl_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import sacl_pkg::*;
`include "assert_macros.svh"

  cfg_t                 cfg;
  st_t                  state_r;
  st_t                  state_nxt;
  logic                 in_acc;
  logic                 advance;
  logic [ADDR_BITS-1:0] addr;
  logic [SHIFT_W-1:0]   sb;
  logic [SB_CFG_W-1:0]  s_eff;
  logic [SET_W-1:0]     set_nxt;
  logic [ADDR_BITS-1:0] tag_nxt;
  logic [SET_W-1:0]     set_r;
  logic [ADDR_BITS-1:0] tag_r;
  logic [NUM_SETS-1:0]  row_ok_r;
  row_t                 row_rd;
  row_t                 row_wr;
  look_res_t            res;
  logic                 out_valid_r;
  logic                 out_hit_r;
  logic                 out_evict_r;
  logic [CNT_W-1:0]     hit_cnt_r;
  logic [CNT_W-1:0]     miss_cnt_r;
  logic [CNT_W-1:0]     evict_cnt_r;

  sacl_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .cfg        (cfg)
  );

  // address split into set index and tag
  always_comb begin
    addr    = in_item.access_address[ADDR_BITS-1:0];
    s_eff   = (int'(cfg.set_bits) > MAX_SET_BITS) ? SB_CFG_W'(MAX_SET_BITS) : cfg.set_bits;
    sb      = SHIFT_W'(s_eff) + SHIFT_W'(cfg.block_bits);
    tag_nxt = (int'(sb) >= ADDR_BITS) ? '0 : (addr >> sb);
    set_nxt = SET_W'(addr >> cfg.block_bits) & ~({SET_W{1'b1}} << s_eff);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_LOOK;
      ST_LOOK: if (advance) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs of the sequencer
  always_comb begin
    in_item.ready = 1'b0;
    advance       = 1'b0;
    case (state_r)
      ST_IDLE: in_item.ready = 1'b1;
      ST_LOOK: advance = !out_valid_r || out_item.ready;
      default: advance = 1'b0;
    endcase
  end

  assign in_acc = in_item.valid && in_item.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // access address held for the compare cycle
  always_ff @(posedge clk) begin
    if (in_acc) begin
      set_r <= set_nxt;
      tag_r <= tag_nxt;
    end
  end

  // tag store: one row per set, read on accept, written back on advance
  sacl_ram #(
    .WIDTH(ROW_W),
    .DEPTH(NUM_SETS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (advance),
    .wr_addr(set_r),
    .wr_data(row_wr),
    .rd_en  (in_acc),
    .rd_addr(set_nxt),
    .rd_data(row_rd)
  );

  // per-set written flags stand in for the reset of valid bits and ranks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_ok_r <= '0;
    end else if (advance) begin
      row_ok_r[set_r] <= 1'b1;
    end
  end

  sacl_lookup u_lookup (
    .row_rd   (row_rd),
    .row_ok   (row_ok_r[set_r]),
    .tag      (tag_r),
    .ways_used(cfg.ways_used),
    .row_wr   (row_wr),
    .res      (res)
  );

  // saturating totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
    end else if (advance) begin
      if (res.hit && hit_cnt_r != '1) hit_cnt_r <= hit_cnt_r + CNT_W'(1);
      if (!res.hit && miss_cnt_r != '1) miss_cnt_r <= miss_cnt_r + CNT_W'(1);
      if (res.evict && evict_cnt_r != '1) evict_cnt_r <= evict_cnt_r + CNT_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_item.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_hit_r   <= res.hit;
      out_evict_r <= res.evict;
    end
  end

  assign out_item.valid       = out_valid_r;
  assign out_item.was_hit     = out_hit_r;
  assign out_item.did_evict   = out_evict_r;
  assign out_item.hit_total   = hit_cnt_r;
  assign out_item.miss_total  = miss_cnt_r;
  assign out_item.evict_total = evict_cnt_r;

  // checks
  `SACL_ASSERT(a_res_after_look, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == ST_LOOK), "result appeared without a lookup")
  `SACL_ASSERT(a_one_flag, clk, rst_n, advance |-> !(res.hit && res.evict), "hit and eviction on one item")
  `SACL_ASSERT(a_no_overwrite, clk, rst_n, (out_valid_r && !out_item.ready) |=> $stable(out_hit_r) && $stable(hit_cnt_r), "waiting result changed")
  `SACL_ASSERT_ALWAYS(a_wr_in_look, clk, advance |-> state_r == ST_LOOK, "tag ram written outside lookup")
endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// testbench for the set-associative lru cache tag store: directed and random access
// streams checked item by item against a behavioral tag store with lru ranks
// depends on sacl_pkg, sacl_if and the set_assoc_cache_lru_sim rtl
module tb;
  import sacl_pkg::*;

  localparam int          ITEMS_PER_PHASE = 125;
  localparam int          NUM_PHASES      = 10;
  localparam int          SETTLE_CYCLES   = 4;
  localparam int          STALL_LIMIT     = 5000;
  localparam logic [1:0]  REG_UNUSED      = 2'd3;

  typedef struct packed {
    logic             was_hit;
    logic             did_evict;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] evict_total;
  } access_outcome_t;

  logic clk;
  logic rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  sacl_in_if  in_ch ();
  sacl_out_if out_ch ();

  set_assoc_cache_lru_sim dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_ch),
    .out_item   (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // behavioral copy of the tag store and registers
  logic [SB_CFG_W-1:0]  cur_set_bits;
  logic [BB_CFG_W-1:0]  cur_block_bits;
  logic [WU_CFG_W-1:0]  cur_ways_used;
  logic                 way_valid [NUM_SETS][MAX_WAYS];
  logic [ADDR_BITS-1:0] way_tag   [NUM_SETS][MAX_WAYS];
  logic [RANK_W-1:0]    way_rank  [NUM_SETS][MAX_WAYS];
  logic [CNT_W-1:0]     hit_count;
  logic [CNT_W-1:0]     miss_count;
  logic [CNT_W-1:0]     evict_count;

  logic [ADDR_BITS-1:0] pending_addrs [$];
  access_outcome_t      outcome_q [$];

  int   mismatch_count;
  int   in_idle_pct;
  int   out_idle_pct;
  int   stall_cycles;
  logic in_taken;

  always #10 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic int eff_set_bits();
    return (cur_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(cur_set_bits);
  endfunction

  function automatic int eff_ways();
    if (cur_ways_used == 0) return 1;
    return (cur_ways_used > MAX_WAYS) ? MAX_WAYS : int'(cur_ways_used);
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // look up one access, update tags and ranks, and queue the outcome
  function automatic void lookup_and_update(input logic [ADDR_BITS-1:0] addr);
    int s, b, sb, ways, set_idx, hit_way, free_way, w, old_rank;
    logic [ADDR_BITS-1:0] tag;
    access_outcome_t res;
    s = eff_set_bits();
    b = cur_block_bits;
    sb = s + b;
    ways = eff_ways();
    tag = (sb >= ADDR_BITS) ? '0 : addr >> sb;
    set_idx = int'((addr >> b) & ((64'd1 << s) - 1));
    hit_way = -1;
    free_way = -1;
    res = '0;
    for (int i = 0; i < ways; i++) begin
      if (way_valid[set_idx][i] && way_tag[set_idx][i] == tag && hit_way < 0) hit_way = i;
      if (!way_valid[set_idx][i] && free_way < 0) free_way = i;
    end
    if (hit_way >= 0) begin
      res.was_hit = 1'b1;
      hit_count = sat_inc(hit_count);
      w = hit_way;
      old_rank = way_rank[set_idx][w];
    end else if (free_way >= 0) begin
      miss_count = sat_inc(miss_count);
      w = free_way;
      way_valid[set_idx][w] = 1'b1;
      way_tag[set_idx][w] = tag;
      // a fresh fill is older than everything, so every valid way below the top rank ages
      old_rank = MAX_WAYS;
    end else begin
      res.did_evict = 1'b1;
      miss_count = sat_inc(miss_count);
      evict_count = sat_inc(evict_count);
      w = 0;
      for (int i = 1; i < ways; i++)
        if (way_rank[set_idx][i] > way_rank[set_idx][w]) w = i;
      way_tag[set_idx][w] = tag;
      old_rank = way_rank[set_idx][w];
    end
    // age the ways that were younger than the touched one
    for (int i = 0; i < ways; i++) begin
      if (i != w && way_valid[set_idx][i] && int'(way_rank[set_idx][i]) < old_rank &&
          way_rank[set_idx][i] != '1)
        way_rank[set_idx][i] = way_rank[set_idx][i] + 1'b1;
    end
    way_rank[set_idx][w] = '0;
    res.hit_total = hit_count;
    res.miss_total = miss_count;
    res.evict_total = evict_count;
    outcome_q.push_back(res);
  endfunction

  // address from a small tag and set pool so that hits and evictions are common
  function automatic logic [ADDR_BITS-1:0] pick_address(input logic [ADDR_BITS-1:0] tag_base);
    int s, b, sb;
    logic [ADDR_BITS-1:0] addr;
    s = eff_set_bits();
    b = cur_block_bits;
    sb = s + b;
    if ($urandom_range(99) < 10) return {$urandom, $urandom};
    addr = (sb >= ADDR_BITS) ? '0 : (tag_base ^ 64'($urandom_range(eff_ways() + 1))) << sb;
    addr |= (64'($urandom_range(3)) & ((64'd1 << s) - 1)) << b;
    addr |= {$urandom, $urandom} & ((64'd1 << b) - 1);
    return addr;
  endfunction

  task automatic cfg_write(input logic [1:0] idx, input logic [CFG_DW-1:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_SET_BITS:   cur_set_bits   = data[SB_CFG_W-1:0];
      REG_BLOCK_BITS: cur_block_bits = data[BB_CFG_W-1:0];
      REG_WAYS_USED:  cur_ways_used  = data[WU_CFG_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic cfg_check(input logic [1:0] idx, input logic [CFG_DW-1:0] want);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== want)
      report_mismatch($sformatf("register %0d reads %h, want %h", idx, cfg_prdata, want));
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic check_registers();
    cfg_check(REG_SET_BITS, CFG_DW'(cur_set_bits));
    cfg_check(REG_BLOCK_BITS, CFG_DW'(cur_block_bits));
    cfg_check(REG_WAYS_USED, CFG_DW'(cur_ways_used));
  endtask

  // random junk above the register field checks that it is masked off
  task automatic write_registers(input int sbits, input int bbits, input int ways);
    cfg_write(REG_SET_BITS, ($urandom << 8) | CFG_DW'(sbits));
    cfg_write(REG_BLOCK_BITS, ($urandom << 8) | CFG_DW'(bbits));
    cfg_write(REG_WAYS_USED, ($urandom << 8) | CFG_DW'(ways));
  endtask

  // wait until every queued access has come back, then let the block settle;
  // checked at the rising edge, where the driver's queue and valid agree
  task automatic drain();
    while (pending_addrs.size() != 0 || in_ch.valid || outcome_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // access driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (pending_addrs.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.access_address <= pending_addrs.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // monitor: predict on each accepted access, check each accepted result
  always @(posedge clk) begin
    access_outcome_t want;
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) lookup_and_update(in_ch.access_address);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (outcome_q.size() == 0) begin
        report_mismatch("result with no access outstanding");
      end else begin
        want = outcome_q.pop_front();
        if (out_ch.was_hit !== want.was_hit)
          report_mismatch($sformatf("was_hit %b, want %b", out_ch.was_hit, want.was_hit));
        if (out_ch.did_evict !== want.did_evict)
          report_mismatch($sformatf("did_evict %b, want %b", out_ch.did_evict, want.did_evict));
        if (out_ch.hit_total !== want.hit_total)
          report_mismatch($sformatf("hit_total %0d, want %0d", out_ch.hit_total,
                                    want.hit_total));
        if (out_ch.miss_total !== want.miss_total)
          report_mismatch($sformatf("miss_total %0d, want %0d", out_ch.miss_total,
                                    want.miss_total));
        if (out_ch.evict_total !== want.evict_total)
          report_mismatch($sformatf("evict_total %0d, want %0d", out_ch.evict_total,
                                    want.evict_total));
      end
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_psel && cfg_penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [ADDR_BITS-1:0] tag_base;
    logic [ADDR_BITS-1:0] acc_a, acc_b, acc_c;
    int sbits, bbits, ways;

    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.access_address = '0;
    out_ch.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_taken = 1'b0;
    stall_cycles = 0;
    mismatch_count = 0;
    in_idle_pct = 12;
    out_idle_pct = 47;
    cur_set_bits = '0;
    cur_block_bits = '0;
    cur_ways_used = WU_CFG_W'(1);
    hit_count = '0;
    miss_count = '0;
    evict_count = '0;
    foreach (way_valid[i, j]) begin
      way_valid[i][j] = 1'b0;
      way_tag[i][j] = '0;
      way_rank[i][j] = '0;
    end

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // reset values, then one way and one set: address extremes, hit and evict
    check_registers();
    pending_addrs = '{64'd0, '1, '1, 64'd0};
    drain();

    // out-of-range set bits and ways, block offset covering almost everything
    write_registers(7, 63, 7);
    cfg_write(REG_UNUSED, '1);
    check_registers();
    pending_addrs = '{'1, 64'd0, 64'h8000_0000_0000_0000, 64'd0};
    drain();

    // two ways filled, then one way in use, producing a duplicate tag
    acc_a = 64'h0123_4567_89ab_cdef;
    acc_b = ~acc_a;
    acc_c = 64'h5555_5555_5555_5555;
    write_registers(0, 0, 2);
    pending_addrs = '{acc_a, acc_b};
    drain();
    cfg_write(REG_WAYS_USED, 0);
    pending_addrs = '{acc_c, acc_b};
    drain();
    // both ways hold the same tag: lowest way wins
    cfg_write(REG_WAYS_USED, 2);
    pending_addrs = '{acc_b, acc_a};
    drain();
    // widen to all ways: fill the free ones, then evict
    cfg_write(REG_WAYS_USED, 4);
    pending_addrs = '{64'h1111, 64'h2222, acc_a, 64'h3333};
    drain();

    // random phases over a spread of register settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 4) begin
        in_idle_pct = 12;
        out_idle_pct = 47;
      end else if (p < 7) begin
        in_idle_pct = 47;
        out_idle_pct = 12;
      end else begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      case (p)
        0: begin sbits = 0; bbits = 0;  ways = 1; end
        1: begin sbits = 6; bbits = 32; ways = 4; end
        2: begin sbits = 7; bbits = 63; ways = 7; end
        3: begin sbits = 2; bbits = 5;  ways = 2; end
        default: begin
          sbits = $urandom_range(7);
          bbits = $urandom_range(63);
          ways = $urandom_range(7);
        end
      endcase
      write_registers(sbits, bbits, ways);
      if ($urandom_range(3) == 0) cfg_write(REG_UNUSED, $urandom);
      check_registers();
      tag_base = {$urandom, $urandom};
      for (int n = 0; n < ITEMS_PER_PHASE; n++) pending_addrs.push_back(pick_address(tag_base));
      drain();
    end

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
